FILE: design/glmu_pkg.sv
// Shared constants, types and small functions of the lattice gauge Metropolis update block.
// No dependencies; glmu_front, glmu_back and the top module import this package.
package glmu_pkg;

  localparam int unsigned DEFAULT_SIDE = 8;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned IN_DATA_W = 40;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned COEF_W = 24;
  localparam int unsigned TOTAL_W = 12;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic COUPLING_H_IDX = 1'b0;
  localparam logic INV_TEMP_IDX = 1'b1;
  localparam logic [COEF_W-1:0] COUPLING_H_RST = 24'd0;
  localparam logic [COEF_W-1:0] INV_TEMP_RST = 24'd65536;

  localparam logic [1:0] DIR_X = 2'd0;
  localparam logic [1:0] DIR_Y = 2'd1;
  localparam logic [1:0] DIR_Z = 2'd2;
  localparam logic [1:0] DIR_NONE = 2'd3;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_RD_N1, ST_RD_N2, ST_EVAL, ST_DECIDE, ST_MUL_X, ST_CHK,
    ST_H_MUL, ST_H_DIV, ST_H_FIX, ST_SQ, ST_PCMP, ST_WB_C, ST_WB_N1, ST_WB_N2, ST_DONE
  } glmu_state_e;

  function automatic logic [2:0] center_mask(input logic [1:0] dir);
    logic [2:0] m;
    unique case (dir)
      DIR_X: m = 3'b101;
      DIR_Y: m = 3'b011;
      DIR_Z: m = 3'b110;
      default: m = 3'b000;
    endcase
    return m;
  endfunction

  function automatic logic [2:0] n1_mask(input logic [1:0] dir);
    logic [2:0] m;
    unique case (dir)
      DIR_X: m = 3'b001;
      DIR_Y: m = 3'b001;
      DIR_Z: m = 3'b010;
      default: m = 3'b000;
    endcase
    return m;
  endfunction

  function automatic logic [2:0] n2_mask(input logic [1:0] dir);
    logic [2:0] m;
    unique case (dir)
      DIR_X: m = 3'b100;
      DIR_Y: m = 3'b010;
      DIR_Z: m = 3'b100;
      default: m = 3'b000;
    endcase
    return m;
  endfunction

  // Floor of 2^32 / k for the Horner divisors two to ten.
  function automatic logic [31:0] recip(input logic [3:0] k);
    logic [31:0] r;
    unique case (k)
      4'd2: r = 32'd2147483648;
      4'd3: r = 32'd1431655765;
      4'd4: r = 32'd1073741824;
      4'd5: r = 32'd858993459;
      4'd6: r = 32'd715827882;
      4'd7: r = 32'd613566756;
      4'd8: r = 32'd536870912;
      4'd9: r = 32'd477218588;
      4'd10: r = 32'd429496729;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: design/glmu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module glmu_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/glmu_front.sv
// Front end: accepts proposals, reduces coordinates, forms the three site addresses
// and holds them in a short queue. Depends on glmu_pkg.
module glmu_front import glmu_pkg::*; #(
  parameter int unsigned LATTICE_SIDE = DEFAULT_SIDE,
  localparam int unsigned SITES = LATTICE_SIDE * LATTICE_SIDE * LATTICE_SIDE,
  localparam int unsigned AW = $clog2(SITES),
  localparam int unsigned CW = $clog2(LATTICE_SIDE)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [IN_DATA_W-1:0] in_data_i,
  input  logic                 clearing_i,
  output logic                 q_valid_o,
  input  logic                 q_pop_i,
  output logic [AW-1:0]        q_addr_c_o,
  output logic [AW-1:0]        q_addr_n1_o,
  output logic [AW-1:0]        q_addr_n2_o,
  output logic [1:0]           q_dir_o,
  output logic [COEF_W-1:0]    q_rand_o
);

  typedef struct packed {
    logic [AW-1:0]     addr_c;
    logic [AW-1:0]     addr_n1;
    logic [AW-1:0]     addr_n2;
    logic [1:0]        dir;
    logic [COEF_W-1:0] rnd;
  } glmu_entry_t;

  function automatic logic [CW-1:0] reduce(input logic [2:0] v);
    int r;
    r = int'(v);
    for (int i = 0; i < 3; i++) begin
      if (r >= int'(LATTICE_SIDE)) begin
        r = r - int'(LATTICE_SIDE);
      end
    end
    return CW'(r);
  endfunction

  function automatic logic [CW-1:0] dec(input logic [CW-1:0] v);
    logic [CW-1:0] r;
    if (v == '0) begin
      r = CW'(LATTICE_SIDE - 1);
    end else begin
      r = v - CW'(1);
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] site(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                         input logic [CW-1:0] z);
    return AW'(int'(x) + int'(LATTICE_SIDE) * int'(y)
               + int'(LATTICE_SIDE) * int'(LATTICE_SIDE) * int'(z));
  endfunction

  logic [CW-1:0] x, y, z, xm, ym, zm;
  logic [1:0] dir;
  glmu_entry_t ent;
  glmu_entry_t fifo_q [QUEUE_DEPTH];
  logic wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic push;

  always_comb begin
    x = reduce(in_data_i[2:0]);
    y = reduce(in_data_i[5:3]);
    z = reduce(in_data_i[8:6]);
    dir = in_data_i[10:9];
    xm = dec(x);
    ym = dec(y);
    zm = dec(z);
    ent.addr_c = site(x, y, z);
    ent.dir = dir;
    ent.rnd = in_data_i[34:11];
    case (dir)
      DIR_X: begin
        ent.addr_n1 = site(x, ym, z);
        ent.addr_n2 = site(x, y, zm);
      end
      DIR_Y: begin
        ent.addr_n1 = site(xm, y, z);
        ent.addr_n2 = site(x, y, zm);
      end
      default: begin
        ent.addr_n1 = site(x, ym, z);
        ent.addr_n2 = site(xm, y, z);
      end
    endcase
  end

  assign in_ready_o = !clearing_i && (cnt_q != 2'(QUEUE_DEPTH));
  assign push = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= ent;
    end
  end

  assign q_valid_o = (cnt_q != 2'd0);
  assign q_addr_c_o = fifo_q[rd_ptr_q].addr_c;
  assign q_addr_n1_o = fifo_q[rd_ptr_q].addr_n1;
  assign q_addr_n2_o = fifo_q[rd_ptr_q].addr_n2;
  assign q_dir_o = fifo_q[rd_ptr_q].dir;
  assign q_rand_o = fifo_q[rd_ptr_q].rnd;

endmodule

FILE: design/glmu_back.sv
// Back end: reads the lattice words, evaluates the Metropolis test with an iterative
// exponential unit, writes the flips back and keeps the running sums. Uses glmu_pkg, glmu_ram.
module glmu_back import glmu_pkg::*; #(
  parameter int unsigned LATTICE_SIDE = DEFAULT_SIDE,
  localparam int unsigned SITES = LATTICE_SIDE * LATTICE_SIDE * LATTICE_SIDE,
  localparam int unsigned AW = $clog2(SITES)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [COEF_W-1:0]     coupling_h_i,
  input  logic [COEF_W-1:0]     beta_i,
  input  logic                  q_valid_i,
  output logic                  q_pop_o,
  input  logic [AW-1:0]         q_addr_c_i,
  input  logic [AW-1:0]         q_addr_n1_i,
  input  logic [AW-1:0]         q_addr_n2_i,
  input  logic [1:0]            q_dir_i,
  input  logic [COEF_W-1:0]     q_rand_i,
  output logic                  clearing_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o
);

  localparam int unsigned CELLS = 3 * SITES;
  localparam int unsigned SW = ($clog2(CELLS + 1) + 1 > TOTAL_W) ? $clog2(CELLS + 1) + 1
                                                                  : TOTAL_W;
  localparam int unsigned DW = 28;

  glmu_state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] ac_q, an1_q, an2_q;
  logic [1:0] dir_q;
  logic [COEF_W-1:0] rnd_q;
  logic [5:0] cw_q, n1w_q, n2w_q;
  logic signed [DW-1:0] dsq_q, dsq_d;
  logic [2:0] nneg_q, nneg_d;
  logic [50:0] x_q;
  logic [30:0] t_q, v_q;
  logic [31:0] e_q, e_d;
  logic [62:0] prod_q, prod2_q;
  logic [3:0] k_q, k_d;
  logic [2:0] sq_q, sq_d;
  logic acc_q, acc_d;
  logic signed [SW-1:0] lsum_q, lsum_d, psum_q, psum_d;
  logic ov_q, ov_d;
  logic [OUT_DATA_W-1:0] od_q, od_d;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [5:0] wdata, rdata;
  logic pop, slot_free;

  glmu_ram #(.WIDTH(6), .DEPTH(SITES)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign slot_free = !ov_q || out_ready_i;
  assign pop = (state_q == ST_IDLE) && q_valid_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == AW'(SITES - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (pop) begin
          state_d = (q_dir_i == DIR_NONE) ? ST_DONE : ST_RD_N1;
        end
      end
      ST_RD_N1: state_d = ST_RD_N2;
      ST_RD_N2: state_d = ST_EVAL;
      ST_EVAL: state_d = ST_DECIDE;
      ST_DECIDE: state_d = dsq_q[DW-1] ? ST_WB_C : ST_MUL_X;
      ST_MUL_X: state_d = ST_CHK;
      ST_CHK: state_d = (|x_q[50:37]) ? ST_DONE : ST_H_MUL;
      ST_H_MUL: state_d = ST_H_DIV;
      ST_H_DIV: state_d = ST_H_FIX;
      ST_H_FIX: state_d = (k_q == 4'd1) ? ST_SQ : ST_H_MUL;
      ST_SQ: if (sq_q == 3'd4) state_d = ST_PCMP;
      ST_PCMP: state_d = acc_d ? ST_WB_C : ST_DONE;
      ST_WB_C: state_d = ST_WB_N1;
      ST_WB_N1: state_d = ST_WB_N2;
      ST_WB_N2: state_d = ST_DONE;
      ST_DONE: if (slot_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    logic [2:0] cm;
    logic [31:0] q0, q;
    logic [31:0] rem;
    logic signed [DW-1:0] pterm, hterm;
    logic [3:0] neg;
    logic [24:0] p;
    cm = center_mask(dir_q);
    q0 = {1'b0, prod2_q[62:32]};
    rem = {1'b0, v_q} - q0 * {28'd0, k_q};
    q = (k_q == 4'd1) ? {1'b0, v_q} : ((rem >= {28'd0, k_q}) ? q0 + 32'd1 : q0);
    neg = 4'($countones(cw_q[5:3] & cm)) + 4'(|(n1w_q[5:3] & n1_mask(dir_q)))
          + 4'(|(rdata[5:3] & n2_mask(dir_q)));
    pterm = DW'(signed'(5'sd4 - 5'(neg << 1))) <<< 16;
    hterm = DW'(signed'(coupling_h_i));
    if (cw_q[dir_q]) begin
      hterm = -hterm;
    end
    p = 25'((33'(e_q) + 33'd64) >> 7);

    clr_d = clr_q;
    e_d = e_q;
    k_d = k_q;
    sq_d = sq_q;
    acc_d = acc_q;
    dsq_d = dsq_q;
    nneg_d = nneg_q;
    lsum_d = lsum_q;
    psum_d = psum_q;
    ov_d = ov_q && !out_ready_i;
    od_d = od_q;
    we = 1'b0;
    waddr = ac_q;
    wdata = '0;
    raddr = ac_q;
    unique case (state_q)
      ST_CLEAR: begin
        we = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + AW'(1);
      end
      ST_IDLE: begin
        raddr = q_addr_c_i;
        acc_d = 1'b0;
      end
      ST_RD_N1: raddr = an1_q;
      ST_RD_N2: raddr = an2_q;
      ST_EVAL: begin
        nneg_d = neg[2:0];
        dsq_d = (pterm + hterm) <<< 1;
      end
      ST_DECIDE: acc_d = dsq_q[DW-1];
      ST_CHK: begin
        e_d = 32'h8000_0000;
        k_d = 4'd10;
        sq_d = 3'd0;
      end
      ST_H_FIX: begin
        e_d = 32'h8000_0000 - q;
        k_d = k_q - 4'd1;
      end
      ST_SQ: begin
        e_d = 32'((64'(e_q) * 64'(e_q)) >> 31);
        sq_d = sq_q + 3'd1;
      end
      ST_PCMP: acc_d = ({1'b0, rnd_q} < p);
      ST_WB_C: begin
        we = 1'b1;
        waddr = ac_q;
        wdata = cw_q ^ {cm, 3'(1) << dir_q};
        lsum_d = cw_q[dir_q] ? lsum_q + SW'(2) : lsum_q - SW'(2);
        psum_d = psum_q - SW'(8) + SW'({nneg_q, 2'b00});
      end
      ST_WB_N1: begin
        we = 1'b1;
        waddr = an1_q;
        wdata = n1w_q ^ {n1_mask(dir_q), 3'b000};
      end
      ST_WB_N2: begin
        we = 1'b1;
        waddr = an2_q;
        wdata = n2w_q ^ {n2_mask(dir_q), 3'b000};
      end
      ST_DONE: begin
        if (slot_free) begin
          ov_d = 1'b1;
          od_d = {7'd0, psum_q[TOTAL_W-1:0], lsum_q[TOTAL_W-1:0], acc_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q <= '0;
      k_q <= 4'd0;
      sq_q <= 3'd0;
      acc_q <= 1'b0;
      lsum_q <= SW'(CELLS);
      psum_q <= SW'(CELLS);
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      k_q <= k_d;
      sq_q <= sq_d;
      acc_q <= acc_d;
      lsum_q <= lsum_d;
      psum_q <= psum_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      ac_q <= q_addr_c_i;
      an1_q <= q_addr_n1_i;
      an2_q <= q_addr_n2_i;
      dir_q <= q_dir_i;
      rnd_q <= q_rand_i;
    end
    if (state_q == ST_RD_N1) cw_q <= rdata;
    if (state_q == ST_RD_N2) n1w_q <= rdata;
    if (state_q == ST_EVAL) n2w_q <= rdata;
    if (state_q == ST_MUL_X) x_q <= 51'(beta_i) * 51'(dsq_q[26:0]);
    if (state_q == ST_CHK) t_q <= x_q[36:6];
    if (state_q == ST_H_MUL) prod_q <= 63'(t_q) * 63'(e_q);
    if (state_q == ST_H_DIV) begin
      v_q <= prod_q[61:31];
      prod2_q <= 63'(prod_q[61:31]) * 63'(recip(k_q));
    end
    dsq_q <= dsq_d;
    nneg_q <= nneg_d;
    e_q <= e_d;
    od_q <= od_d;
  end

  assign q_pop_o = pop;
  assign clearing_o = (state_q == ST_CLEAR);
  assign out_valid_o = ov_q;
  assign out_data_o = od_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !pop) else $error("item taken during clearing pass");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == ST_CLEAR || state_q == ST_WB_C || state_q == ST_WB_N1
            || state_q == ST_WB_N2)) else $error("lattice write outside write-back");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_H_MUL) |-> (k_q >= 4'd1 && k_q <= 4'd10 && e_q <= 32'h8000_0000))
    else $error("exponential unit out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WB_C) |-> acc_q) else $error("write-back without acceptance");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i) |=> (ov_q && $stable(od_q)))
    else $error("stalled result word changed");

endmodule

FILE: design/gauge_lattice_metropolis_update.sv
// Metropolis update of a Z2 gauge lattice: the input stream carries one proposal per word
// (tdata: site_x, site_y, site_z, direction, random_u from bit 0 up) and the output stream
// one result word per proposal (tdata: accepted, link_total, plaquette_total from bit 0 up).
// coupling_h (address 0) and inverse_temperature (address 4) are written over APB; the user must
// write them only while idle, which the block itself does not enforce. After reset the lattice
// memory is cleared, one site a cycle, over all LATTICE_SIDE^3 sites (512 at the default side);
// s_axis_tready stays low meanwhile. Every spin is then +1 and both totals are 3*LATTICE_SIDE^3.
// A two-entry queue sits between the front end and the sequencer, so proposals are taken while
// a result waits. Items are worked one at a time, first in the queue and then in the
// sequencer: direction 3 skips the test, a negative action change is accepted without the
// exponential, an action change with beta*dS of 32 or more is rejected without it, and a full
// exponential evaluation runs ten Horner steps (two multiplies and a correction each) and
// five squarings; every accepted item ends with the three write-backs.
// When m_axis_tready is low the result is held and the sequencer stops after its write-back;
// the queue keeps accepting until it is full. Uses glmu_pkg, glmu_front, glmu_back.
module gauge_lattice_metropolis_update import glmu_pkg::*; #(
  parameter int unsigned LATTICE_SIDE = DEFAULT_SIDE
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // site_x[2:0], site_y[5:3], site_z[8:6], direction[10:9], random_u[34:11]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // accepted[0], link_total[12:1], plaquette_total[24:13]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int unsigned SITES = LATTICE_SIDE * LATTICE_SIDE * LATTICE_SIDE;
  localparam int unsigned AW = $clog2(SITES);

  logic [COEF_W-1:0] coupling_h_q, beta_q;
  logic clearing, q_valid, q_pop;
  logic [AW-1:0] q_addr_c, q_addr_n1, q_addr_n2;
  logic [1:0] q_dir;
  logic [COEF_W-1:0] q_rand;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coupling_h_q <= COUPLING_H_RST;
      beta_q <= INV_TEMP_RST;
    end else if (wr_en) begin
      if (paddr[2] == COUPLING_H_IDX) begin
        coupling_h_q <= pwdata[COEF_W-1:0];
      end else begin
        beta_q <= pwdata[COEF_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == INV_TEMP_IDX) ? {8'd0, beta_q} : {8'd0, coupling_h_q};

  glmu_front #(.LATTICE_SIDE(LATTICE_SIDE)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .clearing_i (clearing),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_addr_c_o (q_addr_c),
    .q_addr_n1_o(q_addr_n1),
    .q_addr_n2_o(q_addr_n2),
    .q_dir_o    (q_dir),
    .q_rand_o   (q_rand)
  );

  glmu_back #(.LATTICE_SIDE(LATTICE_SIDE)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coupling_h_i(coupling_h_q),
    .beta_i      (beta_q),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_addr_c_i  (q_addr_c),
    .q_addr_n1_i (q_addr_n1),
    .q_addr_n2_i (q_addr_n2),
    .q_dir_i     (q_dir),
    .q_rand_i    (q_rand),
    .clearing_o  (clearing),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
